>>> rtl/leaderboard_stable_sort_top_k_top_macros.svh
// Assertion macros for the leaderboard block.
// The asserting module supplies clk and arst_n.
`ifndef LEADERBOARD_STABLE_SORT_TOP_K_TOP_MACROS_SVH
`define LEADERBOARD_STABLE_SORT_TOP_K_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define LB_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbsort: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define LB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbsort: next-cycle check failed");

`endif

>>> rtl/lbsort_pkg.sv
package lbsort_pkg;

	localparam int LB_MAX_SLOTS = 64;
	localparam int LB_TOP_COUNT = 5;

	localparam int LB_CAR_W  = 16;
	localparam int LB_LAPS_W = 10;
	localparam int LB_BOX_W  = 8;
	localparam int LB_TEAM_W = 6;
	localparam int LB_CPT_W  = 7;

	localparam logic [LB_CPT_W-1:0] LB_CPT_RESET = 7'd2;
	localparam logic [LB_CPT_W-1:0] LB_CPT_MAX   = 7'd64;

	// One stored slot record
	typedef struct packed {
		logic [LB_TEAM_W-1:0] team;
		logic [LB_BOX_W-1:0]  box_stops;
		logic [LB_LAPS_W-1:0] laps;
		logic [LB_CAR_W-1:0]  car_number;
		logic                 present;
	} lb_rec_t;

	// Sequencer states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_OUT  = 3'b100
	} lb_state_t;

	// Zero counts as one car per team, large values saturate
	function automatic logic [LB_CPT_W-1:0] lb_clamp_cpt(input logic [LB_CPT_W-1:0] v);
		logic [LB_CPT_W-1:0] r;
		if (v == '0) begin
			r = 7'd1;
		end else if (v > LB_CPT_MAX) begin
			r = LB_CPT_MAX;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

>>> rtl/lbsort_ifs.sv
// Slot word channel
interface lbsort_slot_if;
	import lbsort_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 present;
	logic [LB_CAR_W-1:0]  car_number;
	logic [LB_LAPS_W-1:0] laps;
	logic [LB_BOX_W-1:0]  box_stops;
	logic                 last_slot;

	modport source(output valid, present, car_number, laps, box_stops, last_slot,
		input ready);
	modport sink(input valid, present, car_number, laps, box_stops, last_slot,
		output ready);
endinterface

// Report word channel
interface lbsort_report_if;
	import lbsort_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [LB_CAR_W-1:0]  car_number_out;
	logic [LB_TEAM_W-1:0] team_index;
	logic [LB_LAPS_W-1:0] laps_out;
	logic [LB_BOX_W-1:0]  box_stops_out;
	logic                 is_last_place;
	logic                 no_car;
	logic                 end_of_run;

	modport source(output valid, car_number_out, team_index, laps_out, box_stops_out,
		is_last_place, no_car, end_of_run, input ready);
	modport sink(input valid, car_number_out, team_index, laps_out, box_stops_out,
		is_last_place, no_car, end_of_run, output ready);
endinterface

// Cars-per-team register write channel
interface lbsort_cfg_if;
	import lbsort_pkg::*;
	logic                valid;
	logic                ready;
	logic [LB_CPT_W-1:0] data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

>>> rtl/lbsort_ram.sv
module lbsort_ram #(
	parameter int WIDTH = 41,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

>>> rtl/leaderboard_stable_sort_top_k_top.sv
// Leaderboard: ranks a table of car slots by laps and reports the leaders.
// Channels: slot (valid/ready) carries one slot word per cycle in slot order;
// cfg (valid/ready, always ready) writes cars_per_team; the user writes only
// while idle (not enforced); report (valid/ready) returns the ranked words.
// Loading: one slot word per cycle. The word with last_slot starts the report
// and the slot channel stays not ready until the final report word is taken.
// Report: the shared compare unit scans the stored table once per reported
// rank (one RAM read per cycle, registered data), and each word waits in the
// output register until taken. With n present cars the report holds
// min(n, TOP_COUNT) ranked words and then the last-place word with end_of_run;
// an empty table gives one no_car word. Equal laps keep load order.
// Reset: counters and output valid/end flags clear at once, cars_per_team
// goes to 2; the record RAM is not cleared, no clearing pass is needed.
// A stalled receiver holds the current report word in the output register
// and the scan sequencer waits.
module leaderboard_stable_sort_top_k_top #(
	parameter int MAX_SLOTS = lbsort_pkg::LB_MAX_SLOTS,
	parameter int TOP_COUNT = lbsort_pkg::LB_TOP_COUNT
) (
	input  logic         clk,
	input  logic         arst_n,
	lbsort_slot_if.sink  slot,
	lbsort_cfg_if.sink   cfg,
	lbsort_report_if.source report
);
	import lbsort_pkg::*;

	localparam int AW = $clog2(MAX_SLOTS);
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int PW = $clog2(TOP_COUNT + 1);
	localparam int MW = (CW > PW) ? CW : PW;

	lb_state_t state_q;

	logic [LB_CPT_W-1:0]  cpt_q;
	logic [CW-1:0]        loaded_q;
	logic [LB_TEAM_W-1:0] team_q;
	logic [LB_TEAM_W-1:0] pos_q;

	logic [CW-1:0]        rd_cnt_q;
	logic                 rd_vld_s1;
	logic [AW-1:0]        rd_idx_s1;
	logic [PW-1:0]        pass_q;
	logic [CW-1:0]        n_q;
	lb_rec_t              best_q;
	logic [AW-1:0]        best_idx_q;
	logic                 best_vld_q;
	logic [LB_LAPS_W-1:0] prev_laps_q;
	logic [AW-1:0]        prev_idx_q;
	lb_rec_t              last_rec_q;
	logic                 more_q;

	logic                 out_vld_q;
	logic [LB_CAR_W-1:0]  out_car_q;
	logic [LB_TEAM_W-1:0] out_team_q;
	logic [LB_LAPS_W-1:0] out_laps_q;
	logic [LB_BOX_W-1:0]  out_box_q;
	logic                 out_lastpl_q;
	logic                 out_nocar_q;
	logic                 out_end_q;

	logic                 slot_acc;
	logic                 store_we;
	lb_rec_t              wr_rec;
	lb_rec_t              rd_rec;
	logic [$bits(lb_rec_t)-1:0] rd_raw;
	logic                 rd_en;
	logic                 scan_done;
	logic                 cand;
	logic                 take_best;
	logic                 take_last;
	logic                 out_take;
	logic [PW-1:0]        pass_next;
	logic                 more_next;
	logic [LB_CPT_W-1:0]  cpt_eff;
	logic                 team_wrap;

	// Handshakes
	assign slot.ready = (state_q == ST_IDLE);
	assign cfg.ready  = 1'b1;
	assign slot_acc   = slot.valid && slot.ready;
	assign out_take   = out_vld_q && report.ready;

	// Record write on load
	assign store_we = slot_acc && (loaded_q < CW'(MAX_SLOTS));
	always_comb begin
		wr_rec            = '0;
		wr_rec.present    = slot.present;
		wr_rec.car_number = slot.car_number;
		wr_rec.laps       = slot.laps;
		wr_rec.box_stops  = slot.box_stops;
		wr_rec.team       = team_q;
	end

	assign rd_en = (state_q == ST_SCAN) && (rd_cnt_q < loaded_q);

	lbsort_ram #(
		.WIDTH($bits(lb_rec_t)),
		.DEPTH(MAX_SLOTS)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (loaded_q[AW-1:0]),
		.wdata (wr_rec),
		.re    (rd_en),
		.raddr (rd_cnt_q[AW-1:0]),
		.rdata (rd_raw)
	);
	assign rd_rec = lb_rec_t'(rd_raw);

	// Team tagging
	assign cpt_eff   = lb_clamp_cpt(cpt_q);
	assign team_wrap = ({1'b0, pos_q} + 7'd1) >= cpt_eff;

	// Shared compare unit: next record in rank order after the previous pick
	always_comb begin
		cand = rd_vld_s1 && rd_rec.present &&
			((pass_q == '0) || (rd_rec.laps < prev_laps_q) ||
			((rd_rec.laps == prev_laps_q) && (rd_idx_s1 > prev_idx_q)));
		take_best = cand && (!best_vld_q || (rd_rec.laps > best_q.laps));
		take_last = rd_vld_s1 && rd_rec.present && (pass_q == '0) &&
			((n_q == '0) || (rd_rec.laps <= last_rec_q.laps));
	end

	assign scan_done = (state_q == ST_SCAN) && (rd_cnt_q == loaded_q) && !rd_vld_s1;
	assign pass_next = pass_q + PW'(1);
	assign more_next = (pass_next < PW'(TOP_COUNT)) && (MW'(pass_next) < MW'(n_q));

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpt_q <= LB_CPT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			cpt_q <= cfg.data;
		end
	end

	// Load counters; clear after the final report word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			team_q   <= '0;
			pos_q    <= '0;
		end else if (out_take && out_end_q) begin
			loaded_q <= '0;
			team_q   <= '0;
			pos_q    <= '0;
		end else if (store_we) begin
			loaded_q <= loaded_q + CW'(1);
			if (team_wrap) begin
				pos_q  <= '0;
				team_q <= team_q + LB_TEAM_W'(1);
			end else begin
				pos_q <= pos_q + LB_TEAM_W'(1);
			end
		end
	end

	// Read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
		end
	end
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_cnt_q[AW-1:0];
	end

	// Candidate payload registers
	always_ff @(posedge clk) begin
		if (take_best) begin
			best_q     <= rd_rec;
			best_idx_q <= rd_idx_s1;
		end
		if (take_last) begin
			last_rec_q <= rd_rec;
		end
		if (scan_done) begin
			prev_laps_q <= best_q.laps;
			prev_idx_q  <= best_idx_q;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_cnt_q   <= '0;
			pass_q     <= '0;
			n_q        <= '0;
			best_vld_q <= 1'b0;
			more_q     <= 1'b0;
			out_vld_q  <= 1'b0;
			out_end_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (slot_acc && slot.last_slot) begin
						state_q    <= ST_SCAN;
						rd_cnt_q   <= '0;
						pass_q     <= '0;
						n_q        <= '0;
						best_vld_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end
					if (take_best) begin
						best_vld_q <= 1'b1;
					end
					if (rd_vld_s1 && rd_rec.present && (pass_q == '0)) begin
						n_q <= n_q + CW'(1);
					end
					if (scan_done) begin
						state_q   <= ST_OUT;
						out_vld_q <= 1'b1;
						if (n_q == '0) begin
							out_end_q <= 1'b1;
						end else begin
							out_end_q <= 1'b0;
							pass_q    <= pass_next;
							more_q    <= more_next;
						end
					end
				end
				ST_OUT: begin
					if (out_take) begin
						if (out_end_q) begin
							state_q   <= ST_IDLE;
							out_vld_q <= 1'b0;
							out_end_q <= 1'b0;
						end else if (more_q) begin
							state_q    <= ST_SCAN;
							out_vld_q  <= 1'b0;
							rd_cnt_q   <= '0;
							best_vld_q <= 1'b0;
						end else begin
							out_end_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q   <= ST_IDLE;
					out_vld_q <= 1'b0;
					out_end_q <= 1'b0;
				end
			endcase
		end
	end

	// Output word payload
	always_ff @(posedge clk) begin
		if (scan_done) begin
			if (n_q == '0) begin
				out_car_q    <= '0;
				out_team_q   <= '0;
				out_laps_q   <= '0;
				out_box_q    <= '0;
				out_lastpl_q <= 1'b0;
				out_nocar_q  <= 1'b1;
			end else begin
				out_car_q    <= best_q.car_number;
				out_team_q   <= best_q.team;
				out_laps_q   <= best_q.laps;
				out_box_q    <= best_q.box_stops;
				out_lastpl_q <= 1'b0;
				out_nocar_q  <= 1'b0;
			end
		end else if ((state_q == ST_OUT) && out_take && !out_end_q && !more_q) begin
			out_car_q    <= last_rec_q.car_number;
			out_team_q   <= last_rec_q.team;
			out_laps_q   <= last_rec_q.laps;
			out_box_q    <= last_rec_q.box_stops;
			out_lastpl_q <= 1'b1;
			out_nocar_q  <= 1'b0;
		end
	end

	assign report.valid          = out_vld_q;
	assign report.car_number_out = out_car_q;
	assign report.team_index     = out_team_q;
	assign report.laps_out       = out_laps_q;
	assign report.box_stops_out  = out_box_q;
	assign report.is_last_place  = out_lastpl_q;
	assign report.no_car         = out_nocar_q;
	assign report.end_of_run     = out_end_q;

`include "leaderboard_stable_sort_top_k_top_macros.svh"

	`LB_ASSERT_IMPLIES(a_no_load_during_report, report.valid, !slot.ready)
	`LB_ASSERT_IMPLIES(a_loaded_bound, 1'b1, loaded_q <= CW'(MAX_SLOTS))
	`LB_ASSERT_NEXT(a_clear_after_run, out_take && out_end_q, (loaded_q == '0) && slot.ready)
	`LB_ASSERT_IMPLIES(a_read_only_in_scan, rd_vld_s1, state_q == ST_SCAN)

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
	import lbsort_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int ITEM_TARGET = 260;
	localparam int IDLE_PAD    = 8;
	localparam int END_PAD     = 100;
	localparam int DRAIN_LIMIT = 20000;

	// One slot word as offered on the input channel
	typedef struct packed {
		logic                 present;
		logic [LB_CAR_W-1:0]  car;
		logic [LB_LAPS_W-1:0] laps;
		logic [LB_BOX_W-1:0]  box;
		logic                 last;
	} slot_t;

	// One report word as expected on the output channel
	typedef struct packed {
		logic [LB_CAR_W-1:0]  car;
		logic [LB_TEAM_W-1:0] team;
		logic [LB_LAPS_W-1:0] laps;
		logic [LB_BOX_W-1:0]  box;
		logic                 last_place;
		logic                 none;
		logic                 eor;
	} word_t;

	logic clk = 1'b0;
	logic arst_n;

	lbsort_slot_if   slot_ch();
	lbsort_cfg_if    cfg_ch();
	lbsort_report_if rep_ch();

	leaderboard_stable_sort_top_k_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.slot   (slot_ch),
		.cfg    (cfg_ch),
		.report (rep_ch)
	);

	always #10 clk = ~clk;

	// Predicted block state
	lb_rec_t             tbl_rec [LB_MAX_SLOTS];
	int                  tbl_count;
	logic [LB_TEAM_W-1:0] team_ctr;
	int                  team_pos;
	logic [LB_CPT_W-1:0] cpt_reg;

	word_t pending_words[$];

	int  errors      = 0;
	int  slots_sent  = 0;
	int  tables_done = 0;
	int  words_seen  = 0;
	int  cfg_writes  = 0;
	bit  slot_gaps   = 1'b0;
	bit  rx_gaps     = 1'b0;
	int  hold_reqs   = 0;
	int  hold_done   = 0;

	task automatic flag_mismatch(input string what, input int got, input int want);
		errors++;
		$display("MISMATCH %s: got %0d, want %0d (report word %0d)", what, got, want,
			words_seen);
	endtask

	// Store one slot, advance the team counters, and rank the table on its last slot
	task automatic enter_slot(input slot_t s);
		lb_rec_t r;
		int      order [LB_MAX_SLOTS];
		int      n;
		int      i;
		int      j;
		int      cur;
		int      cpt;
		word_t   w;
		if (tbl_count < LB_MAX_SLOTS) begin
			r.present    = s.present;
			r.car_number = s.car;
			r.laps       = s.laps;
			r.box_stops  = s.box;
			r.team       = team_ctr;
			tbl_rec[tbl_count] = r;
			tbl_count++;
			cpt = int'(cpt_reg);
			if (cpt == 0) cpt = 1;
			if (cpt > int'(LB_CPT_MAX)) cpt = int'(LB_CPT_MAX);
			if (team_pos + 1 >= cpt) begin
				team_pos = 0;
				team_ctr = team_ctr + LB_TEAM_W'(1);
			end else begin
				team_pos++;
			end
		end
		if (s.last) begin
			n = 0;
			for (i = 0; i < tbl_count; i++) begin
				if (tbl_rec[i].present) begin
					order[n] = i;
					n++;
				end
			end
			// stable insertion: only strictly lower laps move down
			for (i = 1; i < n; i++) begin
				cur = order[i];
				j = i;
				while (j > 0 && tbl_rec[order[j-1]].laps < tbl_rec[cur].laps) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = cur;
			end
			if (n == 0) begin
				w = '0;
				w.none = 1'b1;
				w.eor  = 1'b1;
				pending_words.push_back(w);
			end else begin
				for (i = 0; i < n + 1 && i <= LB_TOP_COUNT; i++) begin
					r = (i < n && i < LB_TOP_COUNT) ? tbl_rec[order[i]] : tbl_rec[order[n-1]];
					w.car        = r.car_number;
					w.team       = r.team;
					w.laps       = r.laps;
					w.box        = r.box_stops;
					w.none       = 1'b0;
					w.last_place = !(i < n && i < LB_TOP_COUNT);
					w.eor        = w.last_place;
					pending_words.push_back(w);
					if (w.last_place) break;
				end
			end
			tbl_count = 0;
			team_ctr  = '0;
			team_pos  = 0;
			tables_done++;
		end
	endtask

	function automatic slot_t mk_slot(input logic pres, input logic [LB_CAR_W-1:0] car,
		input logic [LB_LAPS_W-1:0] laps, input logic [LB_BOX_W-1:0] box, input logic last);
		slot_t s;
		s.present = pres;
		s.car     = car;
		s.laps    = laps;
		s.box     = box;
		s.last    = last;
		return s;
	endfunction

	// Random slot; low lap counts often, to force ties
	function automatic slot_t rand_slot(input int pres_pct);
		slot_t s;
		s.present = ($urandom_range(99) < pres_pct);
		s.car     = LB_CAR_W'($urandom_range(16'hFFFF));
		if ($urandom_range(99) < 40) s.laps = LB_LAPS_W'($urandom_range(3));
		else s.laps = LB_LAPS_W'($urandom_range(1023));
		s.box     = LB_BOX_W'($urandom_range(255));
		s.last    = 1'b0;
		return s;
	endfunction

	function automatic logic [LB_CPT_W-1:0] pick_cpt();
		logic [LB_CPT_W-1:0] v;
		case ($urandom_range(6))
			0: v = 7'd0;
			1: v = 7'd1;
			2: v = 7'd64;
			3: v = 7'd65;
			4: v = 7'd127;
			default: v = LB_CPT_W'($urandom_range(64, 1));
		endcase
		return v;
	endfunction

	// Offer one slot word, with an occasional gap ahead of it
	task automatic send_slot(input slot_t s);
		@(negedge clk);
		if (slot_gaps && $urandom_range(99) < 27) begin
			slot_ch.valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		slot_ch.valid      <= 1'b1;
		slot_ch.present    <= s.present;
		slot_ch.car_number <= s.car;
		slot_ch.laps       <= s.laps;
		slot_ch.box_stops  <= s.box;
		slot_ch.last_slot  <= s.last;
		@(posedge clk);
		while (!slot_ch.ready) @(posedge clk);
		enter_slot(s);
		slots_sent++;
	endtask

	task automatic send_table(input int len, input int pres_pct);
		slot_t s;
		for (int i = 0; i < len; i++) begin
			s = rand_slot(pres_pct);
			s.last = (i == len - 1);
			send_slot(s);
		end
	endtask

	task automatic release_slot();
		@(negedge clk);
		slot_ch.valid <= 1'b0;
	endtask

	// Hold the sender until every expected word has come back
	task automatic wait_idle();
		release_slot();
		while (pending_words.size() != 0) @(posedge clk);
		repeat (IDLE_PAD) @(posedge clk);
	endtask

	task automatic write_cpt(input logic [LB_CPT_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cpt_reg = v;
		cfg_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Reset value of two cars per team, field extremes and ties at the top and middle
	task automatic test_default_team();
		send_slot(mk_slot(1'b1, 16'd0,     10'd1023, 8'd255, 1'b0));
		send_slot(mk_slot(1'b1, 16'hFFFF,  10'd0,    8'd0,   1'b0));
		send_slot(mk_slot(1'b0, 16'h5A5A,  10'd700,  8'd3,   1'b0));
		send_slot(mk_slot(1'b1, 16'd12,    10'd500,  8'd7,   1'b0));
		send_slot(mk_slot(1'b1, 16'd13,    10'd500,  8'd8,   1'b0));
		send_slot(mk_slot(1'b1, 16'hFFFF,  10'd1023, 8'd0,   1'b1));
	endtask

	// One present car reported as leader and again as last place
	task automatic test_single_car();
		slot_t s;
		write_cpt(7'd3);
		s = rand_slot(0);
		send_slot(s);
		s = rand_slot(100);
		send_slot(s);
		s = rand_slot(0);
		s.last = 1'b1;
		send_slot(s);
		s = rand_slot(100);
		s.last = 1'b1;
		send_slot(s);
	endtask

	// Tables with no present car give a single no-car word
	task automatic test_no_car();
		send_table(3, 0);
		send_table(1, 0);
	endtask

	// Zero taken as one, large values saturate
	task automatic test_cpt_limits();
		write_cpt(7'd0);
		send_table(4, 100);
		write_cpt(7'd127);
		send_table(4, 100);
	endtask

	// More slots than the store holds; extras dropped, team counter wraps
	task automatic test_overflow();
		write_cpt(7'd1);
		send_table(LB_MAX_SLOTS + 6, 85);
	endtask

	// Receiver stalls a long time so the next table backs up at the input
	task automatic test_backpressure();
		write_cpt(7'd2);
		hold_reqs++;
		send_table(8, 85);
		send_table(8, 85);
		wait_idle();
	endtask

	// Random tables: mostly small, a few large, some sparse or empty
	task automatic test_random();
		int tables;
		int len;
		int pct;
		tables    = 0;
		slot_gaps = 1'b0;
		rx_gaps   = 1'b0;
		while (slots_sent < ITEM_TARGET) begin
			if (tables == 8) begin
				slot_gaps = 1'b1;
				rx_gaps   = 1'b1;
			end
			if (tables % 4 == 3) write_cpt(pick_cpt());
			if ($urandom_range(7) == 0) len = $urandom_range(LB_MAX_SLOTS, 20);
			else len = $urandom_range(10, 1);
			case ($urandom_range(9))
				0: pct = 0;
				1: pct = 15;
				default: pct = 85;
			endcase
			send_table(len, pct);
			tables++;
		end
	endtask

	// Drive report ready: long hold on request, else random stalls
	always @(negedge clk) begin
		if (hold_done != hold_reqs) begin
			rep_ch.ready <= 1'b0;
			repeat (HOLD_CYCLES - 1) @(negedge clk);
			hold_done++;
		end else if (rx_gaps && $urandom_range(99) < 27) begin
			rep_ch.ready <= 1'b0;
		end else begin
			rep_ch.ready <= 1'b1;
		end
	end

	// Check each accepted report word against the oldest prediction
	always @(posedge clk) begin
		word_t want;
		if (arst_n && rep_ch.valid && rep_ch.ready) begin
			words_seen++;
			if (pending_words.size() == 0) begin
				flag_mismatch("unexpected report word", 1, 0);
			end else begin
				want = pending_words.pop_front();
				if (rep_ch.car_number_out !== want.car)
					flag_mismatch("car_number_out", int'(rep_ch.car_number_out),
						int'(want.car));
				if (rep_ch.team_index !== want.team)
					flag_mismatch("team_index", int'(rep_ch.team_index), int'(want.team));
				if (rep_ch.laps_out !== want.laps)
					flag_mismatch("laps_out", int'(rep_ch.laps_out), int'(want.laps));
				if (rep_ch.box_stops_out !== want.box)
					flag_mismatch("box_stops_out", int'(rep_ch.box_stops_out),
						int'(want.box));
				if (rep_ch.is_last_place !== want.last_place)
					flag_mismatch("is_last_place", int'(rep_ch.is_last_place),
						int'(want.last_place));
				if (rep_ch.no_car !== want.none)
					flag_mismatch("no_car", int'(rep_ch.no_car), int'(want.none));
				if (rep_ch.end_of_run !== want.eor)
					flag_mismatch("end_of_run", int'(rep_ch.end_of_run), int'(want.eor));
			end
		end
	end

	initial begin
		int waited;
		slot_ch.valid      = 1'b0;
		slot_ch.present    = 1'b0;
		slot_ch.car_number = '0;
		slot_ch.laps       = '0;
		slot_ch.box_stops  = '0;
		slot_ch.last_slot  = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.data        = '0;
		arst_n             = 1'b0;
		tbl_count          = 0;
		team_ctr           = '0;
		team_pos           = 0;
		cpt_reg            = LB_CPT_RESET;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		slot_gaps = 1'b1;
		rx_gaps   = 1'b1;
		test_default_team();
		test_single_car();
		test_no_car();
		test_cpt_limits();
		test_overflow();
		test_backpressure();
		test_random();

		// Drain, then allow for trailing words
		release_slot();
		waited = 0;
		while (pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (END_PAD) @(posedge clk);
		while (pending_words.size() != 0) begin
			flag_mismatch("missing report word", 0, 1);
			void'(pending_words.pop_front());
		end

		$display("Covered %0d slot words in %0d tables, %0d report words checked,",
			slots_sent, tables_done, words_seen);
		$display("%0d cars-per-team writes including zero, one, 64 and saturating values",
			cfg_writes);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Hard stop well past the slowest correct run
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
